### src/cpbt_pkg.sv
// ----------------------------------------------------------------------------
// cpbt_pkg
// types and codes shared by the parameter block transfer engine
// ----------------------------------------------------------------------------
`default_nettype none

package cpbt_pkg;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_BYTE  = 3'd1,
        OP_POLL  = 3'd2,
        OP_SEND  = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_TX     = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_SUM_HI  = 2'd2,
        PH_SUM_LO  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_READ    = 3'd1,
        S_SEND    = 3'd2,
        S_SEND_HI = 3'd3,
        S_SEND_LO = 3'd4
    } t_state;

    localparam logic [7:0] ST_OK              = 8'd0;
    localparam logic [7:0] ST_PAYLOAD_TIMEOUT = 8'd1;
    localparam logic [7:0] ST_HI_TIMEOUT      = 8'd2;
    localparam logic [7:0] ST_LO_TIMEOUT      = 8'd3;
    localparam logic [7:0] ST_MISMATCH        = 8'd4;

    localparam logic [7:0] RETRY_RESET = 8'd10;

    typedef struct packed {
        logic rx_start;
        logic rx_byte;
        logic rx_poll;
        logic send_start;
        logic send_byte;
        logic send_hi;
        logic send_lo;
        logic read_start;
        logic read_load;
    } t_cmd;

    typedef struct packed {
        logic out_valid;
        logic send_last;
    } t_sts;

endpackage

`default_nettype wire

### src/checksummed_parameter_block_transfer.sv
// ----------------------------------------------------------------------------
// checksummed_parameter_block_transfer
// serial parameter block receive, commit, send and read engine
// ----------------------------------------------------------------------------
// requests enter on the s_axis channel: tuser carries the op, tdata the
// received byte and the read index. results leave on m_axis: tuser is the
// kind, tdata the value and payload fail position, tlast ends each run.
// start, byte and poll requests are handled in the cycle they are taken; a
// byte that closes a frame or a poll that times out loads one status result
// in that same cycle. a read returns its byte through the registered buffer
// read, then loads it as the result. a send holds off new requests and emits
// BLOCK_BYTES bytes at one per cycle while m_axis is not stalled, followed by
// the two checksum bytes; the single buffer read port sets that pace.
// a frame is stored in the spare bank and committed by a bank swap.
// after reset the committed block reads as zeros and retry_limit is 10.
// when m_axis stalls, the result register holds; a new request is taken only
// while that register is empty or being drained. retry_limit must be written
// via i_cfg_we / i_cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module checksummed_parameter_block_transfer #(
    parameter int BLOCK_BYTES = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [15:0] i_s_axis_tdata,   // rx_byte[7:0], read_index[12:8]
    input  wire  [2:0]  i_s_axis_tuser,   // op[2:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // value[7:0], fail_position[13:8]
    output logic [1:0]  o_m_axis_tuser,   // kind[1:0]
    output logic        o_m_axis_tlast,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_wdata
);
    import cpbt_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    t_kind      out_kind;
    logic [7:0] out_value;
    logic [5:0] out_pos;

    cpbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_op       (i_s_axis_tuser),
        .i_m_tready (i_m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cpbt_datapath #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_rx_byte    (i_s_axis_tdata[7:0]),
        .i_read_index (i_s_axis_tdata[12:8]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_m_tready   (i_m_axis_tready),
        .o_sts        (sts),
        .o_out_kind   (out_kind),
        .o_out_value  (out_value),
        .o_out_pos    (out_pos),
        .o_out_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tvalid = sts.out_valid;
    assign o_m_axis_tdata  = {2'b00, out_pos, out_value};
    assign o_m_axis_tuser  = out_kind;

    // read and status results close their run
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != KIND_TX) |-> o_m_axis_tlast)
        else $error("status or read result without tlast");

    // a fail position only comes with a payload timeout status
    a_fail_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[13:8] != 6'd0)
        |-> (o_m_axis_tuser == KIND_STATUS)
            && (o_m_axis_tdata[7:0] == ST_PAYLOAD_TIMEOUT))
        else $error("fail position on a wrong result");

    // a read or send request keeps tready low in the cycle after it is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready
        && ((i_s_axis_tuser == OP_READ) || (i_s_axis_tuser == OP_SEND))
        |=> !o_s_axis_tready)
        else $error("request taken while sequencer busy");

    // a request is never taken while an undelivered result blocks the register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("request taken with result register full");

endmodule

`default_nettype wire

### src/cpbt_ctrl.sv
// ----------------------------------------------------------------------------
// cpbt_ctrl
// request decode and send/read sequencer for the transfer engine
// ----------------------------------------------------------------------------
`default_nettype none

module cpbt_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_tvalid,
    output logic              o_s_tready,
    input  wire         [2:0] i_op,
    input  wire               i_m_tready,
    input  cpbt_pkg::t_sts    i_sts,
    output cpbt_pkg::t_cmd    o_cmd
);
    import cpbt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   load_ok;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign load_ok = !i_sts.out_valid || i_m_tready;
    assign accept  = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = load_ok;
                if (accept) begin
                    case (t_op'(i_op))
                        OP_START: o_cmd.rx_start = 1'b1;
                        OP_BYTE:  o_cmd.rx_byte  = 1'b1;
                        OP_POLL:  o_cmd.rx_poll  = 1'b1;
                        OP_SEND: begin
                            o_cmd.send_start = 1'b1;
                            n_state          = S_SEND;
                        end
                        OP_READ: begin
                            o_cmd.read_start = 1'b1;
                            n_state          = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (load_ok) begin
                    o_cmd.read_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SEND: begin
                if (load_ok) begin
                    o_cmd.send_byte = 1'b1;
                    if (i_sts.send_last) begin
                        n_state = S_SEND_HI;
                    end
                end
            end
            S_SEND_HI: begin
                if (load_ok) begin
                    o_cmd.send_hi = 1'b1;
                    n_state       = S_SEND_LO;
                end
            end
            S_SEND_LO: begin
                if (load_ok) begin
                    o_cmd.send_lo = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### src/cpbt_datapath.sv
// ----------------------------------------------------------------------------
// cpbt_datapath
// banked block buffer, receive checksum engine and result register
// ----------------------------------------------------------------------------
`default_nettype none

module cpbt_datapath #(
    parameter int BLOCK_BYTES = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  cpbt_pkg::t_cmd     i_cmd,
    input  wire          [7:0] i_rx_byte,
    input  wire          [4:0] i_read_index,
    input  wire                i_cfg_we,
    input  wire          [7:0] i_cfg_wdata,
    input  wire                i_m_tready,
    output cpbt_pkg::t_sts     o_sts,
    output cpbt_pkg::t_kind    o_out_kind,
    output logic         [7:0] o_out_value,
    output logic         [5:0] o_out_pos,
    output logic               o_out_last
);
    import cpbt_pkg::*;

    localparam int IW        = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int AW        = IW + 1;
    localparam int MEM_DEPTH = 2 * (2 ** IW);
    localparam logic [5:0] BB6 = 6'(BLOCK_BYTES);

    // two banks: r_bank selects the committed one, the other takes a frame
    logic [7:0]    r_mem [0:MEM_DEPTH-1];
    logic [7:0]    r_rdata;
    logic          r_rd_ok;

    t_phase        r_phase, n_phase;
    logic [5:0]    r_cnt, n_cnt;
    logic [7:0]    r_miss, n_miss;
    logic [15:0]   r_sum, n_sum;
    logic [7:0]    r_hi, n_hi;
    logic          r_bank, n_bank;
    logic          r_cvalid, n_cvalid;
    logic [7:0]    r_retry;
    logic [15:0]   r_tx_sum;
    logic [5:0]    r_send_idx;

    logic          r_out_valid;
    t_kind         r_out_kind;
    logic [7:0]    r_out_value;
    logic [5:0]    r_out_pos;
    logic          r_out_last;

    logic [5:0]    cnt_inc;
    logic [7:0]    miss_inc;
    logic [5:0]    idx_inc;
    logic [5:0]    ri6;
    logic          fin;
    logic [7:0]    fin_code;
    logic [5:0]    fin_pos;
    logic          sh_we;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_val;
    logic          out_load;
    t_kind         ld_kind;
    logic [7:0]    ld_value;
    logic [5:0]    ld_pos;
    logic          ld_last;

    assign cnt_inc  = r_cnt + 6'd1;
    assign miss_inc = r_miss + 8'd1;
    assign idx_inc  = r_send_idx + 6'd1;
    assign ri6      = {1'b0, i_read_index};
    assign rd_val   = (r_cvalid && r_rd_ok) ? r_rdata : 8'd0;

    // receive protocol
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_miss   = r_miss;
        n_sum    = r_sum;
        n_hi     = r_hi;
        n_bank   = r_bank;
        n_cvalid = r_cvalid;
        fin      = 1'b0;
        fin_code = ST_OK;
        fin_pos  = 6'd0;
        sh_we    = 1'b0;
        if (i_cmd.rx_start) begin
            n_phase = PH_PAYLOAD;
            n_cnt   = 6'd0;
            n_miss  = 8'd0;
            n_sum   = 16'd0;
            n_hi    = 8'd0;
        end else if (i_cmd.rx_byte) begin
            case (r_phase)
                PH_PAYLOAD: begin
                    sh_we  = 1'b1;
                    n_sum  = r_sum + {8'd0, i_rx_byte};
                    n_cnt  = cnt_inc;
                    n_miss = 8'd0;
                    if (cnt_inc >= BB6) begin
                        n_phase = PH_SUM_HI;
                    end
                end
                PH_SUM_HI: begin
                    n_hi    = i_rx_byte;
                    n_miss  = 8'd0;
                    n_phase = PH_SUM_LO;
                end
                PH_SUM_LO: begin
                    fin = 1'b1;
                    if ({r_hi, i_rx_byte} == r_sum) begin
                        fin_code = ST_OK;
                        n_bank   = ~r_bank;
                        n_cvalid = 1'b1;
                    end else begin
                        fin_code = ST_MISMATCH;
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.rx_poll && (r_phase != PH_IDLE)) begin
            n_miss = miss_inc;
            if (miss_inc >= r_retry) begin
                fin = 1'b1;
                case (r_phase)
                    PH_PAYLOAD: begin
                        fin_code = ST_PAYLOAD_TIMEOUT;
                        fin_pos  = cnt_inc;
                    end
                    PH_SUM_HI: fin_code = ST_HI_TIMEOUT;
                    default:   fin_code = ST_LO_TIMEOUT;
                endcase
            end
        end
        if (fin) begin
            n_phase = PH_IDLE;
            n_miss  = 8'd0;
        end
    end

    // committed bank read port
    always_comb begin
        rd_en   = i_cmd.read_start || i_cmd.send_start
                  || (i_cmd.send_byte && !o_sts.send_last);
        rd_addr = {r_bank, idx_inc[IW-1:0]};
        if (i_cmd.read_start) begin
            rd_addr = {r_bank, ri6[IW-1:0]};
        end else if (i_cmd.send_start) begin
            rd_addr = {r_bank, {IW{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (sh_we) begin
            r_mem[{~r_bank, r_cnt[IW-1:0]}] <= i_rx_byte;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_rd_ok <= i_cmd.read_start ? (ri6 < BB6) : 1'b1;
        end
    end

    // result selection
    always_comb begin
        out_load = fin || i_cmd.send_byte || i_cmd.send_hi || i_cmd.send_lo
                   || i_cmd.read_load;
        ld_kind  = KIND_TX;
        ld_value = rd_val;
        ld_pos   = 6'd0;
        ld_last  = 1'b0;
        if (fin) begin
            ld_kind  = KIND_STATUS;
            ld_value = fin_code;
            ld_pos   = fin_pos;
            ld_last  = 1'b1;
        end else if (i_cmd.send_hi) begin
            ld_value = r_tx_sum[15:8];
        end else if (i_cmd.send_lo) begin
            ld_value = r_tx_sum[7:0];
            ld_last  = 1'b1;
        end else if (i_cmd.read_load) begin
            ld_kind = KIND_READ;
            ld_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cnt       <= 6'd0;
            r_miss      <= 8'd0;
            r_sum       <= 16'd0;
            r_hi        <= 8'd0;
            r_bank      <= 1'b0;
            r_cvalid    <= 1'b0;
            r_retry     <= RETRY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_miss   <= n_miss;
            r_sum    <= n_sum;
            r_hi     <= n_hi;
            r_bank   <= n_bank;
            r_cvalid <= n_cvalid;
            if (i_cfg_we) begin
                r_retry <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send_start) begin
            r_tx_sum   <= 16'd0;
            r_send_idx <= 6'd0;
        end else if (i_cmd.send_byte) begin
            r_tx_sum   <= r_tx_sum + {8'd0, rd_val};
            r_send_idx <= idx_inc;
        end
        if (out_load) begin
            r_out_kind  <= ld_kind;
            r_out_value <= ld_value;
            r_out_pos   <= ld_pos;
            r_out_last  <= ld_last;
        end
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_sts.send_last = (r_send_idx == (BB6 - 6'd1));
    assign o_out_kind      = r_out_kind;
    assign o_out_value     = r_out_value;
    assign o_out_pos       = r_out_pos;
    assign o_out_last      = r_out_last;

endmodule

`default_nettype wire

### dv/cpbt_result_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpbt_result_monitor
// watches the request and result channels of the parameter block transfer
// engine, tracks the receive frame, the committed block and retry_limit,
// and compares every result in order against the predicted one
// ----------------------------------------------------------------------------
module cpbt_result_monitor #(
    parameter int BLOCK_BYTES = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    input  wire         i_s_axis_tready,
    input  wire  [15:0] i_s_axis_tdata,   // rx_byte[7:0], read_index[12:8]
    input  wire  [2:0]  i_s_axis_tuser,   // op[2:0]
    input  wire         i_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    input  wire  [15:0] i_m_axis_tdata,   // value[7:0], fail_position[13:8]
    input  wire  [1:0]  i_m_axis_tuser,   // kind[1:0]
    input  wire         i_m_axis_tlast,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    import cpbt_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic [5:0] fail_pos;
        logic       last;
    } t_result;

    t_result    expected_results[$];
    logic [7:0] retry_limit;
    logic [7:0] shadow_block [BLOCK_BYTES];
    logic [7:0] committed_block [BLOCK_BYTES];
    t_phase     rx_phase;
    logic [5:0] rx_count;
    logic [7:0] miss_count;
    logic [15:0] rx_sum;
    logic [7:0] rx_sum_hi;

    task automatic push_result(input t_kind kind, input logic [7:0] value,
                               input logic [5:0] fail_pos, input logic last);
        t_result r;
        r.kind     = kind;
        r.value    = value;
        r.fail_pos = fail_pos;
        r.last     = last;
        expected_results.push_back(r);
    endtask

    task automatic close_frame(input logic [7:0] code, input logic [5:0] fail_pos);
        rx_phase   = PH_IDLE;
        miss_count = 8'd0;
        push_result(KIND_STATUS, code, fail_pos, 1'b1);
    endtask

    task automatic apply_request(input logic [2:0] op, input logic [7:0] data_byte,
                                 input logic [4:0] idx);
        logic [15:0] tx_sum;
        int k;
        case (op)
            OP_START: begin
                rx_phase   = PH_PAYLOAD;
                rx_count   = 6'd0;
                miss_count = 8'd0;
                rx_sum     = 16'd0;
                rx_sum_hi  = 8'd0;
            end
            OP_BYTE: begin
                case (rx_phase)
                    PH_PAYLOAD: begin
                        if (rx_count < BLOCK_BYTES)
                            shadow_block[rx_count] = data_byte;
                        rx_sum     = rx_sum + data_byte;
                        rx_count   = rx_count + 6'd1;
                        miss_count = 8'd0;
                        if (rx_count >= BLOCK_BYTES)
                            rx_phase = PH_SUM_HI;
                    end
                    PH_SUM_HI: begin
                        rx_sum_hi  = data_byte;
                        miss_count = 8'd0;
                        rx_phase   = PH_SUM_LO;
                    end
                    PH_SUM_LO: begin
                        if ({rx_sum_hi, data_byte} != rx_sum) begin
                            close_frame(ST_MISMATCH, 6'd0);
                        end else begin
                            for (k = 0; k < BLOCK_BYTES; k++)
                                committed_block[k] = shadow_block[k];
                            close_frame(ST_OK, 6'd0);
                        end
                    end
                    default: ;
                endcase
            end
            OP_POLL: begin
                if (rx_phase != PH_IDLE) begin
                    miss_count = miss_count + 8'd1;
                    if (miss_count >= retry_limit) begin
                        case (rx_phase)
                            PH_PAYLOAD: close_frame(ST_PAYLOAD_TIMEOUT, rx_count + 6'd1);
                            PH_SUM_HI:  close_frame(ST_HI_TIMEOUT, 6'd0);
                            default:    close_frame(ST_LO_TIMEOUT, 6'd0);
                        endcase
                    end
                end
            end
            OP_SEND: begin
                tx_sum = 16'd0;
                for (k = 0; k < BLOCK_BYTES; k++) begin
                    tx_sum = tx_sum + committed_block[k];
                    push_result(KIND_TX, committed_block[k], 6'd0, 1'b0);
                end
                push_result(KIND_TX, tx_sum[15:8], 6'd0, 1'b0);
                push_result(KIND_TX, tx_sum[7:0], 6'd0, 1'b1);
            end
            OP_READ: begin
                push_result(KIND_READ, (idx < BLOCK_BYTES) ? committed_block[idx] : 8'd0,
                            6'd0, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.kind     = t_kind'(i_m_axis_tuser);
        got.value    = i_m_axis_tdata[7:0];
        got.fail_pos = i_m_axis_tdata[13:8];
        got.last     = i_m_axis_tlast;
        if (expected_results.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT)
                $display("%0t: unexpected result kind %0d value %h pos %0d last %b",
                         $time, got.kind, got.value, got.fail_pos, got.last);
        end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
                o_fail_count++;
                if (o_fail_count <= REPORT_LIMIT)
                    $display({"%0t: result mismatch, expected kind %0d value %h pos %0d ",
                              "last %b, got kind %0d value %h pos %0d last %b"},
                             $time, want.kind, want.value, want.fail_pos, want.last,
                             got.kind, got.value, got.fail_pos, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BLOCK_BYTES; k++) begin
                shadow_block[k]    = 8'd0;
                committed_block[k] = 8'd0;
            end
            retry_limit  = RETRY_RESET;
            rx_phase     = PH_IDLE;
            rx_count     = 6'd0;
            miss_count   = 8'd0;
            rx_sum       = 16'd0;
            rx_sum_hi    = 8'd0;
            expected_results.delete();
            o_fail_count = 0;
            o_pending   <= 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready)
                check_result();
            if (i_cfg_we)
                retry_limit = i_cfg_wdata;
            if (i_s_axis_tvalid && i_s_axis_tready)
                apply_request(i_s_axis_tuser, i_s_axis_tdata[7:0], i_s_axis_tdata[12:8]);
            o_pending <= expected_results.size();
        end
    end

endmodule

### dv/tb_checksummed_parameter_block_transfer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checksummed_parameter_block_transfer
// drives receive frames, sends, reads and stray requests into the parameter
// block transfer engine under several retry limits, with bursty requests and
// a stalling result receiver; a monitor predicts and checks every result
// ----------------------------------------------------------------------------
module tb_checksummed_parameter_block_transfer;

    import cpbt_pkg::*;

    localparam int  BLOCK_BYTES  = 32;
    localparam int  TARGET_ITEMS = 480;
    localparam int  NUM_PHASES   = 6;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  CLK_HALF     = 5;
    localparam int  RESET_CYCLES = 11;
    localparam time TIMEOUT_NS   = 5_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = 16'd0;   // rx_byte[7:0], read_index[12:8]
    logic [2:0]  i_s_axis_tuser = 3'd0;    // op[2:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;           // value[7:0], fail_position[13:8]
    logic [1:0]  o_m_axis_tuser;           // kind[1:0]
    logic        o_m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;

    int         fail_count;
    int         pending;
    int         item_count = 0;
    int         burst_left = 0;
    logic [7:0] retry_now = RETRY_RESET;
    int         ready_mode = 0;
    int         ready_mode_left = 0;

    always #CLK_HALF i_clk = ~i_clk;

    checksummed_parameter_block_transfer #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    cpbt_result_monitor #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // result receiver: always ready, random stalls, or mostly stalled
    always @(posedge i_clk) begin
        if (ready_mode_left == 0) begin
            ready_mode      <= $urandom_range(0, 2);
            ready_mode_left <= $urandom_range(20, 200);
        end else begin
            ready_mode_left <= ready_mode_left - 1;
        end
        case (ready_mode)
            0:       i_m_axis_tready <= 1'b1;
            1:       i_m_axis_tready <= ($urandom_range(0, 1) == 0);
            default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_req(input logic [2:0] op, input logic [7:0] data_byte,
                            input logic [4:0] idx);
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 8);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {3'b000, idx, data_byte};
        do @(posedge i_clk); while (!o_s_axis_tready);
        burst_left--;
        if (op <= OP_READ)
            item_count++;
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_retry_limit(input logic [7:0] limit);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        retry_now    = limit;
    endtask

    // one receive frame, mostly well formed; may time out, restart or carry a bad sum
    task automatic run_frame();
        int          eff_limit;
        int          stop_stage;
        int          stage;
        int          n_polls;
        logic [15:0] sum;
        logic [7:0]  data_byte;
        logic [7:0]  flip_mask;
        logic        flip_hi;
        eff_limit  = (retry_now == 8'd0) ? 1 : retry_now;
        stop_stage = ($urandom_range(0, 3) == 0) ? $urandom_range(0, BLOCK_BYTES + 1) : -1;
        flip_mask  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        flip_hi    = 1'($urandom_range(0, 1));
        sum        = 16'd0;
        send_req(OP_START, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
        for (stage = 0; stage < BLOCK_BYTES + 2; stage++) begin
            if (stage == stop_stage) begin
                repeat (eff_limit) send_req(OP_POLL, 8'($urandom_range(0, 255)),
                                            5'($urandom_range(0, 31)));
                return;
            end
            if (eff_limit <= 16 && $urandom_range(0, 7) == 0)
                n_polls = eff_limit - 1;
            else
                n_polls = $urandom_range(0, (eff_limit > 3) ? 2 : eff_limit - 1);
            repeat (n_polls) send_req(OP_POLL, 8'($urandom_range(0, 255)),
                                      5'($urandom_range(0, 31)));
            case ($urandom_range(0, 59))
                0: send_req(OP_READ, 8'($urandom_range(0, 255)),
                            5'($urandom_range(0, 31)));
                1: send_req(OP_SEND, 8'($urandom_range(0, 255)),
                            5'($urandom_range(0, 31)));
                2: send_req(3'($urandom_range(OP_READ + 1, 7)), 8'($urandom_range(0, 255)),
                            5'($urandom_range(0, 31)));
                3: begin
                    send_req(OP_START, 8'($urandom_range(0, 255)),
                             5'($urandom_range(0, 31)));
                    sum   = 16'd0;
                    stage = -1;
                    continue;
                end
                default: ;
            endcase
            if (stage < BLOCK_BYTES) begin
                case ($urandom_range(0, 9))
                    0:       data_byte = 8'h00;
                    1:       data_byte = 8'hFF;
                    default: data_byte = 8'($urandom_range(0, 255));
                endcase
                sum = sum + data_byte;
            end else if (stage == BLOCK_BYTES) begin
                data_byte = sum[15:8] ^ (flip_hi ? flip_mask : 8'd0);
            end else begin
                data_byte = sum[7:0] ^ (flip_hi ? 8'd0 : flip_mask);
            end
            send_req(OP_BYTE, data_byte, 5'($urandom_range(0, 31)));
        end
    endtask

    initial begin
        int         k;
        int         p;
        int         pick;
        logic [7:0] new_limit;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reads at both ends, send of the zero block, ignored requests,
        // a restarted frame and a payload timeout at the reset limit
        send_req(OP_READ, 8'h00, 5'd0);
        send_req(OP_READ, 8'hFF, 5'd31);
        send_req(OP_SEND, 8'h00, 5'd0);
        send_req(OP_BYTE, 8'hFF, 5'd31);
        send_req(OP_POLL, 8'h00, 5'd0);
        for (k = int'(OP_READ) + 1; k < 8; k++)
            send_req(3'(k), 8'hFF, 5'd31);
        send_req(OP_START, 8'h00, 5'd0);
        send_req(OP_BYTE, 8'hFF, 5'd0);
        send_req(OP_BYTE, 8'h00, 5'd0);
        send_req(OP_START, 8'h00, 5'd0);
        repeat (RETRY_RESET) send_req(OP_POLL, 8'h00, 5'd0);

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       new_limit = 8'd1;
                1:       new_limit = 8'd255;
                2:       new_limit = 8'd0;
                3:       new_limit = 8'd3;
                4:       new_limit = 8'($urandom_range(2, 12));
                default: new_limit = 8'd2;
            endcase
            set_retry_limit(new_limit);
            while (item_count < TARGET_ITEMS * (p + 1) / NUM_PHASES) begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    run_frame();
                else if (pick < 62)
                    send_req(OP_SEND, 8'($urandom_range(0, 255)),
                             5'($urandom_range(0, 31)));
                else if (pick < 78)
                    send_req(OP_READ, 8'($urandom_range(0, 255)),
                             5'($urandom_range(0, 31)));
                else if (pick < 96)
                    send_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                             5'($urandom_range(0, 31)));
                else
                    drain_results();
            end
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
